FILE: design/fbam_pkg.sv
// ----------------------------------------------------------------------------
// fbam_pkg
// Shared widths, codes and types of the free bit allocation map.
// ----------------------------------------------------------------------------
package fbam_pkg;

    localparam int MAP_BITS_DEF = 4096;
    localparam int WORD_BITS    = 64;
    localparam int OFS_W        = 6;
    localparam int CNT_W        = 17;
    localparam int COUNT_W      = 13;
    localparam int IDX_W        = 16;
    localparam int FREE_W       = 12;
    localparam int OP_W         = 2;
    localparam int VAL_W        = 2;
    localparam int ST_W         = 2;
    localparam int CFG_IDX_W    = 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4096);

    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ERR  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INODE_COUNT = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACCESS,
        S_SCAN,
        S_RESP
    } t_state;

endpackage

FILE: design/fbam_if.sv
// ----------------------------------------------------------------------------
// fbam request and response channels
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface fbam_req_if import fbam_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic             map_select;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] new_value;

    modport source (output valid, output opcode, output map_select,
                    output entry_index, output new_value, input ready);
    modport sink   (input valid, input opcode, input map_select,
                    input entry_index, input new_value, output ready);
endinterface

interface fbam_rsp_if import fbam_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic              bit_value;
    logic [FREE_W-1:0] free_index;

    modport source (output valid, output status, output bit_value,
                    output free_index, input ready);
    modport sink   (input valid, input status, input bit_value,
                    input free_index, output ready);
endinterface

FILE: design/fbam_map_mem.sv
// ----------------------------------------------------------------------------
// fbam_map_mem
// Word-wide map storage, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fbam_map_mem import fbam_pkg::*; #(
    parameter int ADDR_W = 7
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data
);

    logic [WORD_BITS-1:0] r_mem [2**ADDR_W];
    logic [WORD_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/fbam_word_scan.sv
// ----------------------------------------------------------------------------
// fbam_word_scan
// Lowest free bit of one map word, limited to the entries still in range.
// ----------------------------------------------------------------------------
module fbam_word_scan import fbam_pkg::*; (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [CNT_W-1:0]     i_remain,
    output logic                 o_hit,
    output logic [OFS_W-1:0]     o_ofs
);

    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] free_bits;

    always_comb begin
        if (i_remain >= CNT_W'(WORD_BITS)) begin
            mask = '1;
        end else begin
            mask = (WORD_BITS'(1) << i_remain[OFS_W-1:0]) - WORD_BITS'(1);
        end
        free_bits = ~i_word & mask;
        o_hit = |free_bits;
        o_ofs = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                o_ofs = OFS_W'(b);
            end
        end
    end

endmodule

FILE: design/free_bit_allocation_map_top.sv
// ----------------------------------------------------------------------------
// free_bit_allocation_map_top
// Two allocation bitmaps (data blocks, inodes) with query, set and find.
//
// Requests arrive on i_req, one beat each; every request gives exactly one
// beat on o_rsp. block_count and inode_count are written through the plain
// write port; the user must write them only while the block is idle, which
// the block itself does not enforce. Counts above MAP_BITS act as MAP_BITS.
// Both maps live in one word-wide memory, 64 entries per word, and one
// word scanner is reused for every word of a find. Query and set read the
// word, then modify/write it back, before the result is registered for the
// response; a rejected request goes straight to the response state. Find
// reads one word per cycle from the memory read port. The next request is
// taken once the current one has handed its result to the output register.
// After reset both maps are cleared, one word per cycle, over every word of
// the memory; no request is taken meanwhile. A stalled receiver holds the
// response beat; one further request is finished and then waits until that
// beat leaves.
// ----------------------------------------------------------------------------
module free_bit_allocation_map_top import fbam_pkg::*; #(
    parameter int MAP_BITS = MAP_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    fbam_req_if.sink             i_req,
    fbam_rsp_if.source           o_rsp
);

    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WC_W      = $clog2(MAP_WORDS + 1);
    localparam int MA_W      = WA_W + 1;
    localparam logic [MA_W-1:0]  MEM_LAST  = MA_W'(2**MA_W - 1);
    localparam logic [CNT_W-1:0] MAP_LIMIT = CNT_W'(MAP_BITS);

    t_state               r_state, n_state;
    logic [MA_W-1:0]      r_clr_addr, n_clr_addr;
    logic [COUNT_W-1:0]   r_block_count;
    logic [COUNT_W-1:0]   r_inode_count;
    logic [OP_W-1:0]      r_op, n_op;
    logic                 r_sel, n_sel;
    logic [WA_W-1:0]      r_word, n_word;
    logic [OFS_W-1:0]     r_ofs, n_ofs;
    logic                 r_val, n_val;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WC_W-1:0]      r_next_word, n_next_word;
    logic [WA_W-1:0]      r_eval_word, n_eval_word;
    logic                 r_eval_vld, n_eval_vld;
    logic [ST_W-1:0]      r_res_status, n_res_status;
    logic                 r_res_bit, n_res_bit;
    logic [FREE_W-1:0]    r_res_free, n_res_free;
    logic                 r_out_vld, n_out_vld;
    logic [ST_W-1:0]      r_out_status, n_out_status;
    logic                 r_out_bit, n_out_bit;
    logic [FREE_W-1:0]    r_out_free, n_out_free;

    logic [COUNT_W-1:0]   sel_count;
    logic [CNT_W-1:0]     eff_count;
    logic                 in_range;
    logic [WA_W-1:0]      req_word;
    logic [CNT_W-1:0]     scan_base;
    logic [CNT_W-1:0]     eval_base;
    logic [CNT_W-1:0]     eval_remain;
    logic [CNT_W-1:0]     found_index;
    logic                 issue;
    logic                 last_word;
    logic                 scan_hit;
    logic [OFS_W-1:0]     scan_ofs;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] set_word;
    logic                 mem_wr_en;
    logic [MA_W-1:0]      mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic [MA_W-1:0]      mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;

    fbam_map_mem #(
        .ADDR_W (MA_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    fbam_word_scan u_scan (
        .i_word   (mem_rd_data),
        .i_remain (eval_remain),
        .o_hit    (scan_hit),
        .o_ofs    (scan_ofs)
    );

    assign sel_count = i_req.map_select ? r_inode_count : r_block_count;
    assign eff_count = (CNT_W'(sel_count) > MAP_LIMIT) ? MAP_LIMIT : CNT_W'(sel_count);
    assign in_range  = CNT_W'(i_req.entry_index) < eff_count;
    assign req_word  = i_req.entry_index[WA_W+OFS_W-1:OFS_W];

    assign scan_base   = CNT_W'(r_next_word) << OFS_W;
    assign eval_base   = CNT_W'(r_eval_word) << OFS_W;
    assign eval_remain = r_cnt - eval_base;
    assign found_index = eval_base | CNT_W'(scan_ofs);
    assign issue       = scan_base < r_cnt;
    assign last_word   = (eval_base + CNT_W'(WORD_BITS)) >= r_cnt;

    assign bit_mask = WORD_BITS'(1) << r_ofs;
    assign set_word = r_val ? (mem_rd_data | bit_mask) : (mem_rd_data & ~bit_mask);

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.bit_value  = r_out_bit;
    assign o_rsp.free_index = r_out_free;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_op         = r_op;
        n_sel        = r_sel;
        n_word       = r_word;
        n_ofs        = r_ofs;
        n_val        = r_val;
        n_cnt        = r_cnt;
        n_next_word  = r_next_word;
        n_eval_word  = r_eval_word;
        n_eval_vld   = r_eval_vld;
        n_res_status = r_res_status;
        n_res_bit    = r_res_bit;
        n_res_free   = r_res_free;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_bit    = r_out_bit;
        n_out_free   = r_out_free;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = {r_sel, r_word};
        mem_wr_data  = set_word;
        mem_rd_addr  = {r_sel, r_next_word[WA_W-1:0]};

        unique case (r_state)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_addr;
                mem_wr_data = '0;
                n_clr_addr  = r_clr_addr + MA_W'(1);
                if (r_clr_addr == MEM_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                mem_rd_addr = {i_req.map_select, req_word};
                if (i_req.valid) begin
                    n_op         = i_req.opcode;
                    n_sel        = i_req.map_select;
                    n_word       = req_word;
                    n_ofs        = i_req.entry_index[OFS_W-1:0];
                    n_val        = i_req.new_value[0];
                    n_cnt        = eff_count;
                    n_next_word  = '0;
                    n_eval_vld   = 1'b0;
                    n_res_status = ST_ERR;
                    n_res_bit    = 1'b0;
                    n_res_free   = '0;
                    n_state      = S_RESP;
                    case (i_req.opcode)
                        OP_QUERY: begin
                            if (in_range) begin
                                n_state = S_ACCESS;
                            end
                        end
                        OP_SET: begin
                            if (in_range && !i_req.new_value[1]) begin
                                n_state = S_ACCESS;
                            end
                        end
                        OP_FIND: begin
                            if (eff_count == '0) begin
                                n_res_status = ST_FULL;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ACCESS: begin
                mem_wr_en    = (r_op == OP_SET);
                n_res_status = ST_OK;
                n_res_bit    = (r_op == OP_QUERY) ? mem_rd_data[r_ofs] : 1'b0;
                n_state      = S_RESP;
            end
            S_SCAN: begin
                n_eval_vld  = issue;
                n_eval_word = r_next_word[WA_W-1:0];
                if (issue) begin
                    n_next_word = r_next_word + WC_W'(1);
                end
                if (r_eval_vld) begin
                    if (scan_hit) begin
                        n_res_status = ST_OK;
                        n_res_free   = found_index[FREE_W-1:0];
                        n_state      = S_RESP;
                    end else if (last_word) begin
                        n_res_status = ST_FULL;
                        n_state      = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_bit    = r_res_bit;
                    n_out_free   = r_res_free;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= COUNT_RESET;
            r_inode_count <= COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data;
                CFG_INODE_COUNT: r_inode_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_sel        <= n_sel;
        r_word       <= n_word;
        r_ofs        <= n_ofs;
        r_val        <= n_val;
        r_cnt        <= n_cnt;
        r_next_word  <= n_next_word;
        r_eval_word  <= n_eval_word;
        r_eval_vld   <= n_eval_vld;
        r_res_status <= n_res_status;
        r_res_bit    <= n_res_bit;
        r_res_free   <= n_res_free;
        r_out_status <= n_out_status;
        r_out_bit    <= n_out_bit;
        r_out_free   <= n_out_free;
    end

endmodule
